/* design/rcpa_pkg.sv */
// ----------------------------------------------------------------------------
// rcpa_pkg: shared definitions for the RC channel parameter adjuster
// Constants, configuration bundle, divider request/response and helpers.
// ----------------------------------------------------------------------------
package rcpa_pkg;

  // Shared divider geometry: 28-bit magnitude dividend, 17-bit divisor.
  localparam int DIV_W = 28;
  localparam int DSR_W = 17;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [31:0] DEAD_TIME_MS   = 32'd500;
  localparam logic [31:0] SETTLE_MS      = 32'd100;
  localparam logic [11:0] MOVE_THRESHOLD = 12'd2;
  localparam logic [11:0] MIN_MARGIN     = 12'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_STEP_SIZE      = 3'd0;
  localparam logic [2:0] REG_RANGE_ONE_LOW  = 3'd1;
  localparam logic [2:0] REG_RANGE_ONE_HIGH = 3'd2;
  localparam logic [2:0] REG_RANGE_TWO_LOW  = 3'd3;
  localparam logic [2:0] REG_RANGE_TWO_HIGH = 3'd4;
  localparam logic [2:0] REG_VALUE_MIN      = 3'd5;
  localparam logic [2:0] REG_VALUE_MAX      = 3'd6;

  // Reset values
  localparam logic [7:0]  RST_STEP_SIZE      = 8'd0;
  localparam logic [11:0] RST_RANGE_ONE_LOW  = 12'd900;
  localparam logic [11:0] RST_RANGE_ONE_HIGH = 12'd1300;
  localparam logic [11:0] RST_RANGE_TWO_LOW  = 12'd1700;
  localparam logic [11:0] RST_RANGE_TWO_HIGH = 12'd2100;
  localparam logic [15:0] RST_VALUE_MIN      = 16'd0;
  localparam logic [15:0] RST_VALUE_MAX      = 16'd0;

  typedef struct packed {
    logic [7:0]  step_size;
    logic [11:0] range_one_low;
    logic [11:0] range_one_high;
    logic [11:0] range_two_low;
    logic [11:0] range_two_high;
    logic [15:0] value_min;
    logic [15:0] value_max;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Wrapping time compare: true when now lies before mark.
  function automatic logic time_before(input logic [31:0] now, input logic [31:0] mark);
    logic [31:0] d;
    d = now - mark;
    return d[31];
  endfunction

endpackage

/* design/rc_channel_param_adjuster_unit.sv */
// ----------------------------------------------------------------------------
// rc_channel_param_adjuster_unit: RC channel driven parameter adjuster
// Holds the configuration registers and wraps the sequencer core.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   input   | in        | in_valid / in_stall  | now_ms, channel_value,
//           |           |                      | current_param, enabled, signal_ok
//   output  | out       | out_valid / out_stall| changed, new_value
//   config  | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item is taken only when the core is idle. Disabled, dead-time, settling
// and stepped items, and continuous items with an empty range or span, do not
// use the divider. A continuous item outside the margin makes one divider
// pass; a mapped one makes two passes of the shared 28-step restoring divider
// (margin, then the mapping quotient).
// Reset (rst, synchronous) clears the stored value, timers, last channel and
// loads the register defaults. A stalled result holds in the output register;
// the core waits in its done step until the register frees, then goes idle.
// ----------------------------------------------------------------------------
module rc_channel_param_adjuster_unit
  import rcpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        now_ms,
  input  logic [11:0]        channel_value,
  input  logic signed [15:0] current_param,
  input  logic               enabled,
  input  logic               signal_ok,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic               changed,
  output logic signed [15:0] new_value
);

  cfg_t cfg;

  // Writes land at once, but only while the core is idle.
  assign cfg_ready = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size      <= RST_STEP_SIZE;
      cfg.range_one_low  <= RST_RANGE_ONE_LOW;
      cfg.range_one_high <= RST_RANGE_ONE_HIGH;
      cfg.range_two_low  <= RST_RANGE_TWO_LOW;
      cfg.range_two_high <= RST_RANGE_TWO_HIGH;
      cfg.value_min      <= RST_VALUE_MIN;
      cfg.value_max      <= RST_VALUE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      // truncate the write data to each register's width; drop unknown indexes
      unique case (cfg_index)
        REG_STEP_SIZE:      cfg.step_size      <= cfg_data[7:0];
        REG_RANGE_ONE_LOW:  cfg.range_one_low  <= cfg_data[11:0];
        REG_RANGE_ONE_HIGH: cfg.range_one_high <= cfg_data[11:0];
        REG_RANGE_TWO_LOW:  cfg.range_two_low  <= cfg_data[11:0];
        REG_RANGE_TWO_HIGH: cfg.range_two_high <= cfg_data[11:0];
        REG_VALUE_MIN:      cfg.value_min      <= cfg_data;
        REG_VALUE_MAX:      cfg.value_max      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rcpa_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .now_ms        (now_ms),
    .channel_value (channel_value),
    .current_param (current_param),
    .enabled       (enabled),
    .signal_ok     (signal_ok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .changed       (changed),
    .new_value     (new_value)
  );

endmodule

/* design/rcpa_div.sv */
// ----------------------------------------------------------------------------
// rcpa_div: shared restoring divider
// One quotient bit per cycle; quotient valid with a single-cycle done pulse.
// ----------------------------------------------------------------------------
module rcpa_div
  import rcpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] dq;       // dividend shifts out, quotient shifts in
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] divisor;
  logic [DSR_W:0]   trial;
  logic             fits;

  assign trial = {rem, dq[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      count   <= '0;
      dq      <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      count <= count + CNT_W'(1);
      if (fits) begin
        rem <= DSR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DSR_W-1:0];
      end
      dq <= {dq[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

/* design/rcpa_core.sv */
// ----------------------------------------------------------------------------
// rcpa_core: adjuster sequencer and state
// Decides per item, drives the shared divider, clamps and holds the result.
// ----------------------------------------------------------------------------
module rcpa_core
  import rcpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        now_ms,
  input  logic [11:0]        channel_value,
  input  logic signed [15:0] current_param,
  input  logic               enabled,
  input  logic               signal_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               changed,
  output logic signed [15:0] new_value
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MARGIN,
    S_MUL,
    S_QSTART,
    S_QDIV,
    S_CLAMP,
    S_DONE
  } state_t;

  state_t             state;
  logic [31:0]        now_q;
  logic [11:0]        ch_q;
  logic signed [15:0] cur_q;
  logic               en_q;
  logic               sig_q;

  logic signed [15:0] stored_value;
  logic [31:0]        dead_until;
  logic [31:0]        trigger_at;
  logic [11:0]        last_channel;
  logic signed [31:0] cand;
  logic               res_chg;
  logic               num_neg;
  logic [DIV_W-1:0]   num_abs;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               accept;
  logic               out_free;
  logic [11:0]        ch_diff;
  logic               moved;
  logic               in_r1;
  logic               in_r2;
  logic               rw_pos;
  logic               vw_pos;
  logic [11:0]        rw;
  logic [15:0]        vw;
  logic signed [15:0] vmin;
  logic signed [15:0] vmax;
  logic signed [31:0] vmin32;
  logic signed [31:0] vmax32;
  logic signed [31:0] cur32;
  logic signed [31:0] step32;
  logic [11:0]        q12;
  logic [11:0]        margin;
  logic               in_window;
  logic signed [12:0] offset;
  logic signed [29:0] prod;
  logic signed [29:0] num;
  logic signed [31:0] q32;
  logic signed [31:0] mapped;
  logic signed [15:0] clamped;

  assign accept   = in_valid && !in_stall;
  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign ch_diff = (ch_q >= last_channel) ? ch_q - last_channel : last_channel - ch_q;
  assign moved   = ch_diff > MOVE_THRESHOLD;
  assign in_r1   = (ch_q >= cfg.range_one_low) && (ch_q < cfg.range_one_high);
  assign in_r2   = (ch_q >= cfg.range_two_low) && (ch_q < cfg.range_two_high);

  assign vmin   = $signed(cfg.value_min);
  assign vmax   = $signed(cfg.value_max);
  assign vmin32 = 32'(vmin);
  assign vmax32 = 32'(vmax);
  assign rw_pos = cfg.range_one_high > cfg.range_one_low;
  assign vw_pos = vmax > vmin;
  assign rw     = cfg.range_one_high - cfg.range_one_low;
  assign vw     = cfg.value_max - cfg.value_min;

  assign cur32  = 32'(cur_q);
  assign step32 = $signed({24'b0, cfg.step_size});

  // Margin is max(5, width / (2 * span)); window check without negatives.
  assign q12       = div_rsp.quotient[11:0];
  assign margin    = (q12 < MIN_MARGIN) ? MIN_MARGIN : q12;
  assign in_window = ({1'b0, ch_q} + {1'b0, margin} > {1'b0, cfg.range_one_low}) &&
                     ({1'b0, ch_q} < {1'b0, cfg.range_one_high} + {1'b0, margin});

  assign offset = $signed({1'b0, ch_q}) - $signed({1'b0, cfg.range_one_low});
  assign prod   = offset * $signed({1'b0, vw});
  assign num    = prod + $signed({19'b0, rw[11:1]});

  assign q32    = $signed({{(32-DIV_W){1'b0}}, div_rsp.quotient});
  assign mapped = vmin32 + (num_neg ? -q32 : q32);

  always_comb begin
    if (cand < vmin32) begin
      clamped = vmin;
    end else if (cand > vmax32) begin
      clamped = vmax;
    end else begin
      clamped = cand[15:0];
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = num_abs;
    div_req.divisor  = {1'b0, rw, 4'b0} >> 4;
    unique case (state)
      S_EVAL: begin
        div_req.start    = en_q && sig_q && !time_before(now_q, dead_until) &&
                           cfg.step_size == 8'd0 && rw_pos && vw_pos;
        div_req.dividend = DIV_W'(rw);
        div_req.divisor  = {vw, 1'b0};
      end
      S_QSTART: begin
        div_req.start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  rcpa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_value <= '0;
      dead_until   <= '0;
      trigger_at   <= '0;
      last_channel <= '0;
      res_chg      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now_q   <= now_ms;
            ch_q    <= channel_value;
            cur_q   <= current_param;
            en_q    <= enabled;
            sig_q   <= signal_ok;
            res_chg <= 1'b0;
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          priority if (!(en_q && sig_q) || time_before(now_q, dead_until)) begin
            state <= S_DONE;
          end else if (cfg.step_size != 8'd0) begin
            priority if (moved) begin
              trigger_at   <= now_q + SETTLE_MS;
              last_channel <= ch_q;
              state        <= S_DONE;
            end else if (time_before(now_q, trigger_at)) begin
              state <= S_DONE;
            end else if (in_r1) begin
              cand  <= cur32 - step32;
              state <= S_CLAMP;
            end else if (in_r2) begin
              cand  <= cur32 + step32;
              state <= S_CLAMP;
            end else begin
              state <= S_DONE;
            end
          end else if (rw_pos && vw_pos) begin
            state <= S_MARGIN;
          end else begin
            cand  <= 32'(stored_value);
            state <= S_CLAMP;
          end
        end
        S_MARGIN: begin
          if (div_rsp.done) begin
            if (in_window) begin
              state <= S_MUL;
            end else begin
              cand  <= 32'(stored_value);
              state <= S_CLAMP;
            end
          end
        end
        S_MUL: begin
          num_neg <= num[29];
          num_abs <= num[29] ? DIV_W'(-num) : DIV_W'(num);
          state   <= S_QSTART;
        end
        S_QSTART: begin
          state <= S_QDIV;
        end
        S_QDIV: begin
          if (div_rsp.done) begin
            cand  <= mapped;
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (clamped != stored_value) begin
            stored_value <= clamped;
            dead_until   <= now_q + DEAD_TIME_MS;
            res_chg      <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            changed   <= res_chg;
            new_value <= stored_value;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result presented without passing the done state");

  a_stored_in_clamp: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(stored_value) |-> $past(state) == S_CLAMP)
    else $error("stored value changed outside the clamp step");

  a_dead_time: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(stored_value) |-> dead_until == $past(now_q) + DEAD_TIME_MS)
    else $error("dead time not restarted on change");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> state == S_MARGIN || state == S_QDIV)
    else $error("divider busy outside a divide step");
`endif

endmodule
